### hdl/dfslt_pkg.sv
// Shared types and constants for the dibit frame sync / LICH tracker.
// Depends on nothing; every other file in hdl imports it.
package dfslt_pkg;

    localparam int LICH_LENGTH = 8;
    localparam int LICH_BITS   = 2 * LICH_LENGTH;

    localparam int SYNC_WORD_W = 20;
    localparam int THRESH_W    = 5;
    localparam int MISS_W      = 4;
    localparam int ADV_W       = 10;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int REPORT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ADVANCE  = 2'd3;

    localparam logic [SYNC_WORD_W-1:0] SYNC_WORD_RST      = 20'd843609;
    localparam logic [THRESH_W-1:0]    SYNC_THRESHOLD_RST = 5'd3;
    localparam logic [MISS_W-1:0]      MISS_LIMIT_RST     = 4'd5;
    localparam logic [ADV_W-1:0]       FRAME_ADVANCE_RST  = 10'd144;

    localparam logic [MISS_W-1:0] MISS_SAT = 4'd15;

    typedef enum logic [1:0] {
        EV_LOCK    = 2'd0,
        EV_PRESENT = 2'd1,
        EV_MISS    = 2'd2,
        EV_LOSS    = 2'd3
    } event_t;

    typedef struct packed {
        logic [1:0] rf_ch_kind;
        logic [1:0] func_ch_kind;
        logic [1:0] option_bits;
        logic       direction_flag;
    } lich_t;

endpackage

### hdl/dfslt_window_check.sv
// Window evaluation: sync mismatch count against the sync word, threshold test,
// LICH extraction and parity check. Combinational. Depends on dfslt_pkg.
module dfslt_window_check #(
    parameter int SYNC_LENGTH = 10
) (
    input  logic [2*(SYNC_LENGTH+dfslt_pkg::LICH_LENGTH)-1:0] window,
    input  logic [dfslt_pkg::SYNC_WORD_W-1:0]                 sync_word,
    input  logic [dfslt_pkg::THRESH_W-1:0]                    sync_threshold,
    output logic [dfslt_pkg::REPORT_W-1:0]                    mismatch,
    output logic                                              sync_ok,
    output logic                                              lich_ok,
    output dfslt_pkg::lich_t                                  lich
);
    import dfslt_pkg::*;

    localparam int SB    = 2 * SYNC_LENGTH;
    localparam int WB    = SB + LICH_BITS;
    localparam int MW    = $clog2(SB + 1);
    localparam int CMP_W = (MW > THRESH_W) ? MW : THRESH_W;

    logic [SB-1:0]          sync_pat;
    logic [SB-1:0]          diff;
    logic [MW-1:0]          mm;
    logic [CMP_W-1:0]       mm_ext;
    logic [LICH_LENGTH-1:0] lich_word;

    always_comb
    begin
        for (int i = 0; i < SB; i++)
        begin
            sync_pat[i] = (i < SYNC_WORD_W) ? sync_word[i] : 1'b0;
        end
    end

    assign diff   = window[WB-1:LICH_BITS] ^ sync_pat;
    assign mm     = MW'($countones(diff));
    assign mm_ext = CMP_W'(mm);

    assign sync_ok  = mm_ext <= CMP_W'(sync_threshold);
    assign mismatch = (mm_ext > CMP_W'(31)) ? 5'd31 : REPORT_W'(mm_ext);

    // LICH bit k is the high bit of LICH dibit k (oldest dibit is bit 7)
    always_comb
    begin
        for (int k = 0; k < LICH_LENGTH; k++)
        begin
            lich_word[k] = window[2*k+1];
        end
    end

    assign lich_ok = (lich_word[7] ^ lich_word[6] ^ lich_word[5] ^ lich_word[4]) == lich_word[0];

    assign lich.rf_ch_kind     = lich_word[7:6];
    assign lich.func_ch_kind   = lich_word[5:4];
    assign lich.option_bits    = lich_word[3:2];
    assign lich.direction_flag = lich_word[1];

endmodule

### hdl/dibit_frame_sync_lich_tracker_unit.sv
// Path: an input beat goes into the input register, then window update and
// evaluation write the result register; a dibit may give no result.
// Throughput: one dibit per cycle, single evaluation stage; an unaccepted result stalls it.
// Reset: searching, empty window, counters zero, config registers at defaults.
// Top level of the dibit frame sync and LICH tracker.
// Depends on dfslt_pkg and dfslt_window_check.
module dibit_frame_sync_lich_tracker_unit #(
    parameter int SYNC_LENGTH = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dfslt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dfslt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          dibit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          event_res,
    output logic [4:0]                          mismatch_count,
    output logic [1:0]                          rf_ch_kind,
    output logic [1:0]                          func_ch_kind,
    output logic [1:0]                          option_bits,
    output logic                                direction_flag
);
    import dfslt_pkg::*;

    localparam int WIN_LEN = SYNC_LENGTH + LICH_LENGTH;
    localparam int WB      = 2 * WIN_LEN;
    localparam int FILL_W  = $clog2(WIN_LEN + 1);

    logic [SYNC_WORD_W-1:0] sync_word_reg;
    logic [THRESH_W-1:0]    sync_threshold_reg;
    logic [MISS_W-1:0]      miss_limit_reg;
    logic [ADV_W-1:0]       frame_advance_reg;

    logic       s1_valid_reg;
    logic [1:0] s1_dibit_reg;

    logic [WB-1:0]     window_reg, window_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              locked_reg, locked_next;
    logic [MISS_W-1:0] miss_reg, miss_next;
    logic [ADV_W-1:0]  pos_reg, pos_next;
    logic [ADV_W-1:0]  skip_reg, skip_next;

    logic              out_valid_reg;
    event_t            event_reg, event_next;
    logic [4:0]        mm_reg;
    lich_t             lich_reg, lich_next;

    logic              s2_fire;
    logic              emit;
    logic [REPORT_W-1:0] mm_w;
    logic              sync_ok;
    logic              lich_ok;
    lich_t             lich_w;
    logic [MISS_W-1:0] lim;
    logic [MISS_W-1:0] miss_inc;
    logic [ADV_W-1:0]  pos_inc;

    assign s2_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg      <= SYNC_WORD_RST;
            sync_threshold_reg <= SYNC_THRESHOLD_RST;
            miss_limit_reg     <= MISS_LIMIT_RST;
            frame_advance_reg  <= FRAME_ADVANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_WORD:      sync_word_reg      <= cfg_data[SYNC_WORD_W-1:0];
                CFG_SYNC_THRESHOLD: sync_threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_MISS_LIMIT:     miss_limit_reg     <= cfg_data[MISS_W-1:0];
                CFG_FRAME_ADVANCE:  frame_advance_reg  <= cfg_data[ADV_W-1:0];
                default:            sync_word_reg      <= sync_word_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_dibit_reg <= dibit;
        end
    end

    assign window_next = {window_reg[WB-3:0], s1_dibit_reg};

    dfslt_window_check #(
        .SYNC_LENGTH    (SYNC_LENGTH)
    ) u_check (
        .window         (window_next),
        .sync_word      (sync_word_reg),
        .sync_threshold (sync_threshold_reg),
        .mismatch       (mm_w),
        .sync_ok        (sync_ok),
        .lich_ok        (lich_ok),
        .lich           (lich_w)
    );

    assign lim      = (miss_limit_reg == '0) ? MISS_W'(1) : miss_limit_reg;
    assign miss_inc = (miss_reg < MISS_SAT) ? miss_reg + MISS_W'(1) : miss_reg;
    assign pos_inc  = pos_reg + ADV_W'(1);

    always_comb
    begin
        fill_next   = (fill_reg < FILL_W'(WIN_LEN)) ? fill_reg + FILL_W'(1) : fill_reg;
        locked_next = locked_reg;
        miss_next   = miss_reg;
        pos_next    = pos_reg;
        skip_next   = skip_reg;
        emit        = 1'b0;
        event_next  = EV_LOCK;
        lich_next   = '0;
        if (!locked_reg)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - ADV_W'(1);
            end
            else if (fill_next == FILL_W'(WIN_LEN) && sync_ok && lich_ok)
            begin
                locked_next = 1'b1;
                miss_next   = '0;
                pos_next    = '0;
                emit        = 1'b1;
                event_next  = EV_LOCK;
                lich_next   = lich_w;
            end
        end
        else if (pos_inc < frame_advance_reg)
        begin
            pos_next = pos_inc;
        end
        else
        begin
            pos_next = '0;
            emit     = 1'b1;
            if (sync_ok)
            begin
                miss_next  = '0;
                event_next = EV_PRESENT;
            end
            else if (miss_inc >= lim)
            begin
                locked_next = 1'b0;
                miss_next   = '0;
                skip_next   = (frame_advance_reg == '0) ? '0 : frame_advance_reg - ADV_W'(1);
                event_next  = EV_LOSS;
            end
            else
            begin
                miss_next  = miss_inc;
                event_next = EV_MISS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
            locked_reg <= 1'b0;
            miss_reg   <= '0;
            pos_reg    <= '0;
            skip_reg   <= '0;
        end
        else if (s2_fire)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            locked_reg <= locked_next;
            miss_reg   <= miss_next;
            pos_reg    <= pos_next;
            skip_reg   <= skip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_fire)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && emit)
        begin
            event_reg <= event_next;
            mm_reg    <= mm_w;
            lich_reg  <= lich_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = event_reg;
    assign mismatch_count = mm_reg;
    assign rf_ch_kind     = lich_reg.rf_ch_kind;
    assign func_ch_kind   = lich_reg.func_ch_kind;
    assign option_bits    = lich_reg.option_bits;
    assign direction_flag = lich_reg.direction_flag;

`ifndef SYNTHESIS
    a_lock_sets_locked: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && emit && event_next == EV_LOCK) |=> locked_reg)
        else $error("lock event without entering lock");

    a_loss_clears_lock: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && emit && event_next == EV_LOSS) |=> (!locked_reg && miss_reg == '0))
        else $error("loss event did not return to search");

    a_search_only_locks: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && emit && !locked_reg) |-> (event_next == EV_LOCK))
        else $error("tracking event while searching");

    a_skip_only_searching: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_reg != '0) |-> !locked_reg)
        else $error("resume skip pending while locked");

    a_lich_zero_off_lock: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_res != EV_LOCK) |-> (lich_reg == '0))
        else $error("LICH fields set on a tracking event");
`endif

endmodule
